>>> hw/rtl/palette_to_rgb16_lookup_macros.svh
// Assertion helpers for the lookup RTL.
`ifndef PALETTE_TO_RGB16_LOOKUP_MACROS_SVH
`define PALETTE_TO_RGB16_LOOKUP_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define P2R_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define P2R_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> hw/rtl/pt16_pkg.sv
`timescale 1ns / 1ps

package pt16_pkg;

    localparam int TABLE_ENTRIES = 256;
    localparam int TBL_AW        = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;

    localparam int IDX_W   = 8;
    localparam int LEVEL_W = 6;
    localparam int COLOR_W = 16;
    localparam int KEY_W   = 8;
    localparam int DATA_W  = 32;
    localparam int ADDR_W  = 4;

    localparam logic [COLOR_W-1:0] RED_MASK_RST   = 16'hF800;
    localparam logic [COLOR_W-1:0] GREEN_MASK_RST = 16'h07E0;
    localparam logic [COLOR_W-1:0] BLUE_MASK_RST  = 16'h001F;
    localparam logic [KEY_W-1:0]   KEY_COLOR_RST  = 8'h00;

    typedef enum logic {
        CMD_WRITE = 1'b0,
        CMD_PIXEL = 1'b1
    } t_cmd;

    typedef enum logic [1:0] {
        REG_RED_MASK   = 2'd0,
        REG_GREEN_MASK = 2'd1,
        REG_BLUE_MASK  = 2'd2,
        REG_KEY_COLOR  = 2'd3
    } t_reg_idx;

endpackage

>>> hw/rtl/pt16_if.sv
`timescale 1ns / 1ps

// Pixel / table-write item channel.
interface pt16_item_if;
    logic                              valid;
    logic                              ready;
    logic                              command;
    logic [pt16_pkg::IDX_W-1:0]        palette_index;
    logic [pt16_pkg::LEVEL_W-1:0]      red_level;
    logic [pt16_pkg::LEVEL_W-1:0]      green_level;
    logic [pt16_pkg::LEVEL_W-1:0]      blue_level;
    logic                              use_key;

    modport source (
        output valid, command, palette_index, red_level, green_level, blue_level, use_key,
        input  ready
    );
    modport sink (
        input  valid, command, palette_index, red_level, green_level, blue_level, use_key,
        output ready
    );
endinterface

// Packed color result channel.
interface pt16_result_if;
    logic                              valid;
    logic                              ready;
    logic [pt16_pkg::COLOR_W-1:0]      packed_color;
    logic                              keep_destination;

    modport source (
        output valid, packed_color, keep_destination,
        input  ready
    );
    modport sink (
        input  valid, packed_color, keep_destination,
        output ready
    );
endinterface

>>> hw/rtl/pt16_encode.sv
`timescale 1ns / 1ps

// Builds one packed table entry from three 6-bit levels and the channel masks.
module pt16_encode (
    input  logic [pt16_pkg::LEVEL_W-1:0] i_red_level,
    input  logic [pt16_pkg::LEVEL_W-1:0] i_green_level,
    input  logic [pt16_pkg::LEVEL_W-1:0] i_blue_level,
    input  logic [pt16_pkg::COLOR_W-1:0] i_red_mask,
    input  logic [pt16_pkg::COLOR_W-1:0] i_green_mask,
    input  logic [pt16_pkg::COLOR_W-1:0] i_blue_mask,
    output logic [pt16_pkg::COLOR_W-1:0] o_color
);

    // Highest set bit of a 16-bit mask, zero for an empty mask.
    function automatic logic [3:0] top_bit(input logic [15:0] m_in);
        logic [15:0] m;
        logic [3:0]  pos;
        m   = m_in;
        pos = 4'd0;
        if ((m & 16'hFF00) != 16'h0) begin
            pos[3] = 1'b1;
            m      = m & 16'hFF00;
        end
        if ((m & 16'hF0F0) != 16'h0) begin
            pos[2] = 1'b1;
            m      = m & 16'hF0F0;
        end
        if ((m & 16'hCCCC) != 16'h0) begin
            pos[1] = 1'b1;
            m      = m & 16'hCCCC;
        end
        if ((m & 16'hAAAA) != 16'h0) begin
            pos[0] = 1'b1;
        end
        return pos;
    endfunction

    // Scale to 8 bits, then shift by (top bit - 7). The level is pre-placed
    // 7 bits up and 14 bits are dropped afterwards, so one left shift covers
    // both directions.
    function automatic logic [15:0] place(input logic [5:0] level, input logic [15:0] mask);
        logic [30:0] wide;
        logic [3:0]  hb;
        hb   = top_bit(mask);
        wide = {16'h0, level, 9'h0} << hb;
        return wide[29:14] & mask;
    endfunction

    assign o_color = place(i_red_level, i_red_mask)
                   | place(i_green_level, i_green_mask)
                   | place(i_blue_level, i_blue_mask);

endmodule

>>> hw/rtl/palette_to_rgb16_lookup.sv
`timescale 1ns / 1ps
// Path: stage-1 input register (table read), then stage-2 output register.
// Throughput: one item (pixel or table write) per cycle while the output
//   register takes pixels; set by the single table write/read port, which
//   each item uses once in stage 1.
// Reset (synchronous, active low): masks and key return to defaults, all 256
//   entry-valid flags clear at once, so the table reads zero; no sweep.

module palette_to_rgb16_lookup (
    input  logic                          i_clk,
    input  logic                          i_rst_n,

    pt16_item_if.sink                     i_item,
    pt16_result_if.source                 o_result,

    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [pt16_pkg::ADDR_W-1:0]   paddr,
    input  logic [pt16_pkg::DATA_W-1:0]   pwdata,
    output logic [pt16_pkg::DATA_W-1:0]   prdata,
    output logic                          pready
);

    `include "palette_to_rgb16_lookup_macros.svh"

    // ------------------------------------------------------------------
    // Configuration registers (APB, pready tied high)
    // ------------------------------------------------------------------
    logic [pt16_pkg::COLOR_W-1:0] r_red_mask;
    logic [pt16_pkg::COLOR_W-1:0] r_green_mask;
    logic [pt16_pkg::COLOR_W-1:0] r_blue_mask;
    logic [pt16_pkg::KEY_W-1:0]   r_key_color;
    logic                         cfg_wr;
    pt16_pkg::t_reg_idx           cfg_sel;

    assign pready  = 1'b1;
    assign cfg_wr  = psel & penable & pwrite & pready;
    assign cfg_sel = pt16_pkg::t_reg_idx'(paddr[3:2]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_red_mask   <= pt16_pkg::RED_MASK_RST;
            r_green_mask <= pt16_pkg::GREEN_MASK_RST;
            r_blue_mask  <= pt16_pkg::BLUE_MASK_RST;
            r_key_color  <= pt16_pkg::KEY_COLOR_RST;
        end else if (cfg_wr) begin
            unique case (cfg_sel)
                pt16_pkg::REG_RED_MASK:   r_red_mask   <= pwdata[pt16_pkg::COLOR_W-1:0];
                pt16_pkg::REG_GREEN_MASK: r_green_mask <= pwdata[pt16_pkg::COLOR_W-1:0];
                pt16_pkg::REG_BLUE_MASK:  r_blue_mask  <= pwdata[pt16_pkg::COLOR_W-1:0];
                pt16_pkg::REG_KEY_COLOR:  r_key_color  <= pwdata[pt16_pkg::KEY_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (cfg_sel)
            pt16_pkg::REG_RED_MASK:   prdata = 32'(r_red_mask);
            pt16_pkg::REG_GREEN_MASK: prdata = 32'(r_green_mask);
            pt16_pkg::REG_BLUE_MASK:  prdata = 32'(r_blue_mask);
            pt16_pkg::REG_KEY_COLOR:  prdata = 32'(r_key_color);
            default:                  prdata = '0;
        endcase
    end

    // ------------------------------------------------------------------
    // Stage 1: input register. Writes retire here; pixels move on to the
    // output register only when it can take them.
    // ------------------------------------------------------------------
    logic                              r_s1_valid;
    logic                              r_s1_cmd;
    logic [pt16_pkg::IDX_W-1:0]        r_s1_idx;
    logic [pt16_pkg::LEVEL_W-1:0]      r_s1_red;
    logic [pt16_pkg::LEVEL_W-1:0]      r_s1_green;
    logic [pt16_pkg::LEVEL_W-1:0]      r_s1_blue;
    logic                              r_s1_use_key;

    logic                              r_s2_valid;
    logic                              n_s2_valid;
    logic                              s2_free;
    logic                              s1_is_pixel;
    logic                              s1_go;
    logic                              s1_pix_go;
    logic                              s1_wr_go;
    logic                              in_xfer;
    logic                              s1_in_range;
    logic [pt16_pkg::TBL_AW-1:0]       s1_addr;

    assign s2_free     = !r_s2_valid || o_result.ready;
    assign s1_is_pixel = (r_s1_cmd == pt16_pkg::CMD_PIXEL);
    assign s1_go       = r_s1_valid && (!s1_is_pixel || s2_free);
    assign s1_pix_go   = s1_go && s1_is_pixel;
    assign s1_wr_go    = s1_go && !s1_is_pixel && s1_in_range;
    assign i_item.ready = !r_s1_valid || s1_go;
    assign in_xfer     = i_item.valid && i_item.ready;

    assign s1_in_range = ({1'b0, r_s1_idx} < (pt16_pkg::IDX_W+1)'(pt16_pkg::TABLE_ENTRIES));
    assign s1_addr     = r_s1_idx[pt16_pkg::TBL_AW-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (i_item.ready) begin
            r_s1_valid <= i_item.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_s1_cmd     <= i_item.command;
            r_s1_idx     <= i_item.palette_index;
            r_s1_red     <= i_item.red_level;
            r_s1_green   <= i_item.green_level;
            r_s1_blue    <= i_item.blue_level;
            r_s1_use_key <= i_item.use_key;
        end
    end

    // Entry value for a table write
    logic [pt16_pkg::COLOR_W-1:0] s1_color;

    pt16_encode u_encode (
        .i_red_level   (r_s1_red),
        .i_green_level (r_s1_green),
        .i_blue_level  (r_s1_blue),
        .i_red_mask    (r_red_mask),
        .i_green_mask  (r_green_mask),
        .i_blue_mask   (r_blue_mask),
        .o_color       (s1_color)
    );

    // ------------------------------------------------------------------
    // Color table: one write or one read per cycle, read data registered.
    // Per-entry valid flags stand in for clearing the array on reset.
    // ------------------------------------------------------------------
    logic [pt16_pkg::COLOR_W-1:0]      r_table [pt16_pkg::TABLE_ENTRIES];
    logic [pt16_pkg::TABLE_ENTRIES-1:0] r_tbl_vld;

    always_ff @(posedge i_clk) begin
        if (s1_wr_go) begin
            r_table[s1_addr] <= s1_color;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tbl_vld <= '0;
        end else if (s1_wr_go) begin
            r_tbl_vld[s1_addr] <= 1'b1;
        end
    end

    // ------------------------------------------------------------------
    // Stage 2: output register (holds while the sink stalls)
    // ------------------------------------------------------------------
    logic [pt16_pkg::COLOR_W-1:0] r_s2_data;
    logic                         r_s2_hit;
    logic                         r_s2_keep;
    logic                         s1_keep;

    assign s1_keep = r_s1_use_key && (r_s1_idx == r_key_color);

    always_comb begin
        n_s2_valid = r_s2_valid;
        if (s1_pix_go) begin
            n_s2_valid = 1'b1;
        end else if (o_result.ready) begin
            n_s2_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_valid <= 1'b0;
        end else begin
            r_s2_valid <= n_s2_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_pix_go) begin
            r_s2_data <= r_table[s1_addr];
            r_s2_keep <= s1_keep;
            // Unwritten entries and out-of-range indices read as zero;
            // a keyed match reports zero color as well.
            r_s2_hit  <= !s1_keep && s1_in_range && r_tbl_vld[s1_addr];
        end
    end

    assign o_result.valid            = r_s2_valid;
    assign o_result.packed_color     = r_s2_data & {pt16_pkg::COLOR_W{r_s2_hit}};
    assign o_result.keep_destination = r_s2_keep;

    // ------------------------------------------------------------------
    // Checks
    // ------------------------------------------------------------------
    `P2R_ASSERT_NOW(a_keep_zero, i_clk, i_rst_n,
        o_result.valid && o_result.keep_destination,
        o_result.packed_color == '0, "keyed pixel carries nonzero color")
    `P2R_ASSERT_NEXT(a_write_marks_valid, i_clk, i_rst_n,
        s1_wr_go, r_tbl_vld[$past(s1_addr)], "written entry not marked valid")
    `P2R_ASSERT_NOW(a_result_from_pixel, i_clk, i_rst_n,
        $rose(r_s2_valid), $past(s1_pix_go), "result appeared without a pixel transfer")
    `P2R_ASSERT_NEXT(a_stall_holds, i_clk, i_rst_n,
        r_s2_valid && !o_result.ready,
        r_s2_valid && $stable(o_result.packed_color) && $stable(r_s2_keep),
        "stalled result lost")

endmodule

>>> sim/palette_to_rgb16_lookup_checker.sv
`timescale 1ns / 1ps

module palette_to_rgb16_lookup_checker
    import pt16_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,

    pt16_item_if                i_item,
    pt16_result_if              i_result,

    input  logic                i_psel,
    input  logic                i_penable,
    input  logic                i_pwrite,
    input  logic [ADDR_W-1:0]   i_paddr,
    input  logic [DATA_W-1:0]   i_pwdata,
    input  logic                i_pready,

    output int                  o_outstanding,
    output int                  o_mismatches
);

    typedef struct packed {
        logic [COLOR_W-1:0] packed_color;
        logic               keep_destination;
    } t_pixel_out;

    logic [COLOR_W-1:0] shadow_table [TABLE_ENTRIES];
    logic [COLOR_W-1:0] red_mask;
    logic [COLOR_W-1:0] green_mask;
    logic [COLOR_W-1:0] blue_mask;
    logic [KEY_W-1:0]   key_color;
    t_pixel_out         pending_pixels [$];
    int                 errors;

    initial begin
        o_outstanding = 0;
        o_mismatches  = 0;
        errors        = 0;
    end

    // Highest set bit of a channel mask; an empty mask counts as bit 0.
    function automatic int mask_top_bit(input logic [COLOR_W-1:0] m);
        int pos = 0;
        for (int b = 0; b < COLOR_W; b++) begin
            if (m[b]) begin
                pos = b;
            end
        end
        return pos;
    endfunction

    // 6-bit level -> 8 bits -> aligned to the top of the mask -> masked.
    function automatic logic [COLOR_W-1:0] place_level(input logic [LEVEL_W-1:0] lvl,
                                                      input logic [COLOR_W-1:0] m);
        int          top;
        logic [31:0] v;
        top = mask_top_bit(m);
        v   = {24'd0, lvl, 2'b00};
        if (top > 7) begin
            v = v << (top - 7);
        end else begin
            v = v >> (7 - top);
        end
        return v[COLOR_W-1:0] & m;
    endfunction

    always @(posedge i_clk) begin : predict_and_compare
        t_pixel_out want;
        int         idx;
        if (!i_rst_n) begin
            for (int e = 0; e < TABLE_ENTRIES; e++) begin
                shadow_table[e] = '0;
            end
            red_mask   = RED_MASK_RST;
            green_mask = GREEN_MASK_RST;
            blue_mask  = BLUE_MASK_RST;
            key_color  = KEY_COLOR_RST;
            pending_pixels.delete();
        end else begin
            if (i_psel && i_penable && i_pwrite && i_pready) begin
                case (t_reg_idx'(i_paddr[ADDR_W-1:2]))
                    REG_RED_MASK:   red_mask   = i_pwdata[COLOR_W-1:0];
                    REG_GREEN_MASK: green_mask = i_pwdata[COLOR_W-1:0];
                    REG_BLUE_MASK:  blue_mask  = i_pwdata[COLOR_W-1:0];
                    REG_KEY_COLOR:  key_color  = i_pwdata[KEY_W-1:0];
                    default: ;
                endcase
            end

            if (i_result.valid && i_result.ready) begin
                if (pending_pixels.size() == 0) begin
                    errors++;
                    if (errors <= 10) begin
                        $display("[%0t] unexpected result: color %h keep %b", $realtime,
                                 i_result.packed_color, i_result.keep_destination);
                    end
                end else begin
                    want = pending_pixels.pop_front();
                    if (i_result.packed_color !== want.packed_color ||
                        i_result.keep_destination !== want.keep_destination) begin
                        errors++;
                        if (errors <= 10) begin
                            $display("[%0t] result mismatch: color exp %h got %h, keep exp %b got %b",
                                     $realtime, want.packed_color, i_result.packed_color,
                                     want.keep_destination, i_result.keep_destination);
                        end
                    end
                end
            end

            if (i_item.valid && i_item.ready) begin
                idx = int'(i_item.palette_index);
                if (t_cmd'(i_item.command) == CMD_WRITE) begin
                    if (idx < TABLE_ENTRIES) begin
                        shadow_table[idx] = place_level(i_item.red_level, red_mask)
                                          | place_level(i_item.green_level, green_mask)
                                          | place_level(i_item.blue_level, blue_mask);
                    end
                end else begin
                    if (i_item.use_key && i_item.palette_index == key_color) begin
                        want.packed_color     = '0;
                        want.keep_destination = 1'b1;
                    end else begin
                        want.packed_color     = (idx < TABLE_ENTRIES) ? shadow_table[idx] : '0;
                        want.keep_destination = 1'b0;
                    end
                    pending_pixels.push_back(want);
                end
            end
        end
        o_outstanding <= pending_pixels.size();
        o_mismatches  <= errors;
    end

endmodule

>>> sim/palette_to_rgb16_lookup_test.sv
`timescale 1ns / 1ps

module palette_to_rgb16_lookup_test;
    import pt16_pkg::*;

    localparam int CLK_HALF_NS     = 4;        // 8 ns period
    localparam int RESET_CYCLES    = 8;
    localparam int SETTLE_CYCLES   = 6;        // pipeline is 2 deep; write items leave no result
    localparam int LONG_HOLD       = 80;       // one long receiver hold-off to back up the input
    localparam int ITEMS_PER_PHASE = 100;
    localparam int RUN_LIMIT_NS    = 2_000_000;

    // One item as offered on the input channel.
    typedef struct packed {
        t_cmd                command;
        logic [IDX_W-1:0]    palette_index;
        logic [LEVEL_W-1:0]  red_level;
        logic [LEVEL_W-1:0]  green_level;
        logic [LEVEL_W-1:0]  blue_level;
        logic                use_key;
    } t_item;

    logic                i_clk = 1'b0;
    logic                i_rst_n;
    logic                psel;
    logic                penable;
    logic                pwrite;
    logic [ADDR_W-1:0]   paddr;
    logic [DATA_W-1:0]   pwdata;
    logic [DATA_W-1:0]   prdata;
    logic                pready;

    int                  outstanding;
    int                  mismatches;

    pt16_item_if         item_ch ();
    pt16_result_if       result_ch ();

    // Stimulus bookkeeping: current key, entries written so far, burst length left.
    logic [KEY_W-1:0]    key_now;
    logic [IDX_W-1:0]    written_idx [$];
    int                  burst_left;
    bit                  long_hold_req;

    palette_to_rgb16_lookup dut (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_item    (item_ch),
        .o_result  (result_ch),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready)
    );

    palette_to_rgb16_lookup_checker color_check (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_item         (item_ch),
        .i_result       (result_ch),
        .i_psel         (psel),
        .i_penable      (penable),
        .i_pwrite       (pwrite),
        .i_paddr        (paddr),
        .i_pwdata       (pwdata),
        .i_pready       (pready),
        .o_outstanding  (outstanding),
        .o_mismatches   (mismatches)
    );

    always begin
        #CLK_HALF_NS i_clk = 1'b1;
        #CLK_HALF_NS i_clk = 1'b0;
    end

    function automatic t_item make_item(input t_cmd cmd, input int idx, input int r,
                                        input int g, input int b, input bit keyed);
        t_item it;
        it.command       = cmd;
        it.palette_index = IDX_W'(idx);
        it.red_level     = LEVEL_W'(r);
        it.green_level   = LEVEL_W'(g);
        it.blue_level    = LEVEL_W'(b);
        it.use_key       = keyed;
        return it;
    endfunction

    // Random item, well-formed by construction. The index is steered toward the
    // key color and toward entries already written so both the key match and
    // real table contents show up often; the rest is spread over all 256.
    function automatic t_item random_item();
        t_item it;
        int    pick;
        it.command = ($urandom_range(0, 9) < 4) ? CMD_WRITE : CMD_PIXEL;
        pick = $urandom_range(0, 7);
        if (pick < 2) begin
            it.palette_index = key_now;
        end else if (pick < 5 && written_idx.size() > 0) begin
            it.palette_index = written_idx[$urandom_range(0, written_idx.size() - 1)];
        end else begin
            it.palette_index = IDX_W'($urandom_range(0, 255));
        end
        it.red_level   = LEVEL_W'($urandom_range(0, 63));
        it.green_level = LEVEL_W'($urandom_range(0, 63));
        it.blue_level  = LEVEL_W'($urandom_range(0, 63));
        it.use_key     = 1'($urandom_range(0, 1));
        return it;
    endfunction

    // Offer one item and hold it until the transfer. Items go out in bursts of
    // random length; between bursts valid drops for a random gap (sometimes none).
    task automatic send_item(input t_item it);
        int gap;
        @(negedge i_clk);
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0) begin
                item_ch.valid = 1'b0;
                repeat (gap) @(negedge i_clk);
            end
            burst_left = $urandom_range(1, 24);
        end
        burst_left--;
        item_ch.valid         = 1'b1;
        item_ch.command       = it.command;
        item_ch.palette_index = it.palette_index;
        item_ch.red_level     = it.red_level;
        item_ch.green_level   = it.green_level;
        item_ch.blue_level    = it.blue_level;
        item_ch.use_key       = it.use_key;
        do @(posedge i_clk); while (!item_ch.ready);
        if (it.command == CMD_WRITE) begin
            written_idx.push_back(it.palette_index);
        end
    endtask

    // Stop offering, wait for every pending pixel to come back, then let any
    // trailing table write clear the pipeline.
    task automatic drain();
        @(negedge i_clk);
        item_ch.valid = 1'b0;
        while (outstanding != 0) @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    // Setup cycle, then access cycle; the write lands when pready is seen high.
    task automatic apb_write(input t_reg_idx reg_sel, input logic [DATA_W-1:0] value);
        @(negedge i_clk);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = 1'b1;
        paddr   = {reg_sel, 2'b00};
        pwdata  = value;
        @(negedge i_clk);
        penable = 1'b1;
        do @(posedge i_clk); while (!pready);
        @(negedge i_clk);
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
    endtask

    // Registers change only with the block idle.
    task automatic set_colors(input logic [COLOR_W-1:0] red, input logic [COLOR_W-1:0] green,
                              input logic [COLOR_W-1:0] blue, input logic [KEY_W-1:0] key);
        drain();
        apb_write(REG_RED_MASK, DATA_W'(red));
        apb_write(REG_GREEN_MASK, DATA_W'(green));
        apb_write(REG_BLUE_MASK, DATA_W'(blue));
        apb_write(REG_KEY_COLOR, DATA_W'(key));
        key_now = key;
    endtask

    // Result sink: ready follows a mode picked per segment -- always ready,
    // coin flip, mostly stalled, or a fixed pattern. A long hold-off requested
    // by the stimulus is served here and counted in this process, while the
    // sender keeps offering, so the pipeline fills and input ready drops.
    initial begin : result_sink
        int mode;
        int span;
        int tick;
        result_ch.ready = 1'b0;
        tick = 0;
        wait (i_rst_n === 1'b1);
        forever begin
            if (long_hold_req) begin
                @(negedge i_clk);
                result_ch.ready = 1'b0;
                repeat (LONG_HOLD) @(negedge i_clk);
                long_hold_req = 1'b0;
            end
            mode = $urandom_range(0, 3);
            span = $urandom_range(8, 40);
            repeat (span) begin
                @(negedge i_clk);
                tick++;
                case (mode)
                    0:       result_ch.ready = 1'b1;
                    1:       result_ch.ready = 1'($urandom_range(0, 1));
                    2:       result_ch.ready = ($urandom_range(0, 3) == 0);
                    default: result_ch.ready = (tick % 4 != 0);
                endcase
            end
        end
    end

    initial begin : stimulus
        // Everything known from time zero; reset is held low before the first item.
        i_rst_n               = 1'b0;
        psel                  = 1'b0;
        penable               = 1'b0;
        pwrite                = 1'b0;
        paddr                 = '0;
        pwdata                = '0;
        item_ch.valid         = 1'b0;
        item_ch.command       = CMD_WRITE;
        item_ch.palette_index = '0;
        item_ch.red_level     = '0;
        item_ch.green_level   = '0;
        item_ch.blue_level    = '0;
        item_ch.use_key       = 1'b0;
        key_now               = KEY_COLOR_RST;
        burst_left            = 0;
        long_hold_req         = 1'b0;
        repeat (RESET_CYCLES) @(negedge i_clk);
        i_rst_n = 1'b1;

        // Directed, reset masks (565) and key 0: extreme levels per channel,
        // alternating bit patterns, key hit and miss, unkeyed read of the key
        // index, a never-written entry, and a read right behind its write.
        send_item(make_item(CMD_WRITE, 0,   63, 63, 63, 1'b0));
        send_item(make_item(CMD_WRITE, 255, 63,  0,  0, 1'b0));
        send_item(make_item(CMD_WRITE, 1,    0, 63,  0, 1'b0));
        send_item(make_item(CMD_WRITE, 2,    0,  0, 63, 1'b0));
        send_item(make_item(CMD_WRITE, 3,   42, 21, 42, 1'b1));
        send_item(make_item(CMD_PIXEL, 0,    0,  0,  0, 1'b0));
        send_item(make_item(CMD_PIXEL, 0,   63, 63, 63, 1'b1));
        send_item(make_item(CMD_PIXEL, 255,  0,  0,  0, 1'b1));
        send_item(make_item(CMD_PIXEL, 1,    0,  0,  0, 1'b0));
        send_item(make_item(CMD_PIXEL, 2,    0,  0,  0, 1'b0));
        send_item(make_item(CMD_PIXEL, 3,    0,  0,  0, 1'b0));
        send_item(make_item(CMD_PIXEL, 200,  0,  0,  0, 1'b0));
        send_item(make_item(CMD_WRITE, 0,    0,  0,  0, 1'b0));
        send_item(make_item(CMD_PIXEL, 0,    0,  0,  0, 1'b0));
        send_item(make_item(CMD_WRITE, 128, 21, 42, 21, 1'b0));
        send_item(make_item(CMD_PIXEL, 128,  0,  0,  0, 1'b1));

        // Register settings: full masks (largest left shift) with key 255,
        // empty masks (channels cleared), single-bit / narrow masks, two
        // random sets, then back to 565 with a random key.
        for (int phase = 1; phase <= 6; phase++) begin
            case (phase)
                1:       set_colors(16'hFFFF, 16'hFFFF, 16'hFFFF, 8'hFF);
                2:       set_colors(16'h0000, 16'h0000, 16'h0000, 8'h00);
                3:       set_colors(16'h0001, 16'h8000, 16'h0180, 8'h80);
                4, 5:    set_colors(COLOR_W'($urandom), COLOR_W'($urandom),
                                    COLOR_W'($urandom), KEY_W'($urandom));
                default: set_colors(RED_MASK_RST, GREEN_MASK_RST, BLUE_MASK_RST,
                                    KEY_W'($urandom));
            endcase
            if (phase == 1) begin
                long_hold_req = 1'b1;
            end
            // Full-scale entry under the new masks, read back, then a key hit.
            send_item(make_item(CMD_WRITE, 3 + phase, 63, 63, 63, 1'b0));
            send_item(make_item(CMD_PIXEL, 3 + phase,  0,  0,  0, 1'b0));
            send_item(make_item(CMD_PIXEL, int'(key_now), 0, 0, 0, 1'b1));
            repeat (ITEMS_PER_PHASE) send_item(random_item());
        end

        drain();
        if (mismatches == 0) begin
            $display("palette_to_rgb16_lookup test passed");
        end else begin
            $display("palette_to_rgb16_lookup test failed");
        end
        $finish;
    end

    initial begin : watchdog
        #(RUN_LIMIT_NS);
        $display("palette_to_rgb16_lookup test failed");
        $finish;
    end

endmodule

>>> files.f
+incdir+hw/rtl
hw/rtl/pt16_pkg.sv
hw/rtl/pt16_if.sv
hw/rtl/pt16_encode.sv
hw/rtl/palette_to_rgb16_lookup.sv
sim/palette_to_rgb16_lookup_checker.sv
sim/palette_to_rgb16_lookup_test.sv
